### rtl/linear_key_value_table_assert.svh
// Assertion macros used by the key/value table back end.
`ifndef LINEAR_KEY_VALUE_TABLE_ASSERT_SVH
`define LINEAR_KEY_VALUE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LKVT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LKVT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lkvt_pkg.sv
// Types, codes and default sizes for the linear key/value table.
package lkvt_pkg;

	// Default sizes handed to the top level parameters
	localparam int DEF_CAPACITY    = 16;
	localparam int DEF_KEY_WIDTH   = 32;
	localparam int DEF_VALUE_WIDTH = 32;

	// Fixed port field widths
	localparam int OP_W         = 3;
	localparam int PORT_KEY_W   = 32;
	localparam int PORT_VALUE_W = 32;
	localparam int PORT_SLOT_W  = 4;
	localparam int STATUS_W     = 2;
	localparam int PORT_COUNT_W = 5;

	// Command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;

	// Request operation codes as they arrive on the port
	typedef enum logic [OP_W-1:0] {
		OPC_FIND       = 3'd0,
		OPC_INSERT     = 3'd1,
		OPC_ERASE_KEY  = 3'd2,
		OPC_ERASE_SLOT = 3'd3,
		OPC_CLEAR      = 3'd4
	} op_code_t;

	// Classified command kinds
	typedef enum logic [2:0] {
		CMD_FIND,
		CMD_INSERT,
		CMD_ERASE_KEY,
		CMD_ERASE_SLOT,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_PRESENT = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Back end sequencer states
	typedef enum logic [1:0] {
		BS_IDLE,
		BS_SCAN,
		BS_MOVE,
		BS_DONE
	} back_state_t;

	// Control part of a queued command
	typedef struct packed {
		cmd_kind_t              kind;
		logic [PORT_SLOT_W-1:0] slot;
	} cmd_ctl_t;

endpackage

### rtl/lkvt_ifs.sv
// Request and response channel interfaces of the key/value table.
interface lkvt_req_if;
	import lkvt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic [PORT_KEY_W-1:0]   req_key;
	logic [PORT_VALUE_W-1:0] req_value;
	logic [PORT_SLOT_W-1:0]  req_slot;

	modport source (output valid, operation, req_key, req_value, req_slot, input ready);
	modport sink   (input valid, operation, req_key, req_value, req_slot, output ready);
endinterface

interface lkvt_rsp_if;
	import lkvt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [PORT_VALUE_W-1:0] found_value;
	logic [PORT_SLOT_W-1:0]  found_slot;
	logic [PORT_COUNT_W-1:0] entry_count;

	modport source (output valid, status, found_value, found_slot, entry_count, input ready);
	modport sink   (input valid, status, found_value, found_slot, entry_count, output ready);
endinterface

### rtl/lkvt_ram.sv
// Generic single write port RAM with one registered read port.
module lkvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/lkvt_front.sv
// Front end: decodes requests and queues them for the back end.
module lkvt_front #(
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lkvt_req_if.sink                 req,
	output logic                     cmd_valid,
	input  logic                     cmd_ready,
	output lkvt_pkg::cmd_ctl_t       cmd_ctl,
	output logic [KEY_WIDTH-1:0]     cmd_key,
	output logic [VALUE_WIDTH-1:0]   cmd_value
);
	import lkvt_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int LW = QW + 1;

	cmd_ctl_t               ctl_mem_q [QUEUE_DEPTH];
	logic [KEY_WIDTH-1:0]   key_mem_q [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem_q [QUEUE_DEPTH];
	logic [QW-1:0]          wr_ptr_q;
	logic [QW-1:0]          rd_ptr_q;
	logic [LW-1:0]          level_q;
	cmd_ctl_t               dec_ctl;
	logic                   push;
	logic                   pop;

	// classify the operation code; unknown codes become a no-op
	always_comb begin
		dec_ctl.slot = req.req_slot;
		case (req.operation)
			OPC_FIND:       dec_ctl.kind = CMD_FIND;
			OPC_INSERT:     dec_ctl.kind = CMD_INSERT;
			OPC_ERASE_KEY:  dec_ctl.kind = CMD_ERASE_KEY;
			OPC_ERASE_SLOT: dec_ctl.kind = CMD_ERASE_SLOT;
			OPC_CLEAR:      dec_ctl.kind = CMD_CLEAR;
			default:        dec_ctl.kind = CMD_NOP;
		endcase
	end

	// queue handshakes
	assign req.ready = (level_q != LW'(QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (level_q != '0);
	assign pop       = cmd_valid && cmd_ready;

	assign cmd_ctl   = ctl_mem_q[rd_ptr_q];
	assign cmd_key   = key_mem_q[rd_ptr_q];
	assign cmd_value = val_mem_q[rd_ptr_q];

	// queue storage, only the used key and value bits are kept
	always_ff @(posedge clk) begin
		if (push) begin
			ctl_mem_q[wr_ptr_q] <= dec_ctl;
			key_mem_q[wr_ptr_q] <= KEY_WIDTH'(req.req_key);
			val_mem_q[wr_ptr_q] <= VALUE_WIDTH'(req.req_value);
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			level_q <= level_q + LW'(push) - LW'(pop);
		end
	end
endmodule

### rtl/lkvt_back.sv
// Back end: scans the entry RAM, updates the table and registers the result.
`include "linear_key_value_table_assert.svh"

module lkvt_back #(
	parameter int CAPACITY    = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  lkvt_pkg::cmd_ctl_t     cmd_ctl,
	input  logic [KEY_WIDTH-1:0]   cmd_key,
	input  logic [VALUE_WIDTH-1:0] cmd_value,
	lkvt_rsp_if.source             rsp
);
	import lkvt_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > PORT_SLOT_W) ? CNT_W : PORT_SLOT_W;
	localparam int EW    = KEY_WIDTH + VALUE_WIDTH;

	back_state_t            state_q, state_d;
	cmd_kind_t              kind_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [AW-1:0]          cur_q, cur_d;
	logic [CNT_W-1:0]       count_q, count_d;
	status_t                res_status_q, res_status_d;
	logic [VALUE_WIDTH-1:0] res_value_q, res_value_d;
	logic [AW-1:0]          res_slot_q, res_slot_d;

	logic                   out_valid_q;
	status_t                out_status_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [AW-1:0]          out_slot_q;
	logic [CNT_W-1:0]       out_count_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [EW-1:0]          ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [EW-1:0]          ram_rdata;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;

	logic                   out_free;
	logic                   start;
	logic                   key_op;
	logic                   slot_ok;
	logic                   cnt_empty;
	logic                   tbl_full;
	logic                   hit;
	logic                   below_last;
	logic                   miss_go;
	cmd_kind_t              act_kind;
	logic [KEY_WIDTH-1:0]   act_key;
	logic [VALUE_WIDTH-1:0] act_val;

	// entry storage: key in the upper bits, value in the lower bits
	lkvt_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_key = ram_rdata[EW-1:VALUE_WIDTH];
	assign rd_val = ram_rdata[VALUE_WIDTH-1:0];

	// status terms
	assign out_free   = !out_valid_q || rsp.ready;
	assign cmd_ready  = (state_q == BS_IDLE);
	assign start      = cmd_valid && (state_q == BS_IDLE);
	assign key_op     = (cmd_ctl.kind inside {CMD_FIND, CMD_INSERT, CMD_ERASE_KEY});
	assign slot_ok    = CMP_W'(cmd_ctl.slot) < CMP_W'(count_q);
	assign cnt_empty  = (count_q == '0);
	assign tbl_full   = (count_q == CNT_W'(CAPACITY));
	assign hit        = (kind_q == CMD_ERASE_SLOT) || (rd_key == key_q);
	assign below_last = (CNT_W'(cur_q) + CNT_W'(1)) < count_q;

	// a key lookup ends without a match: empty table at start or scan ran out
	assign miss_go = (start && key_op && cnt_empty) ||
		((state_q == BS_SCAN) && !hit && !below_last);
	assign act_kind = (state_q == BS_IDLE) ? cmd_ctl.kind : kind_q;
	assign act_key  = (state_q == BS_IDLE) ? cmd_key : key_q;
	assign act_val  = (state_q == BS_IDLE) ? cmd_value : val_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (cmd_valid) begin
					case (cmd_ctl.kind)
						CMD_FIND, CMD_INSERT, CMD_ERASE_KEY:
							state_d = cnt_empty ? BS_DONE : BS_SCAN;
						CMD_ERASE_SLOT:
							state_d = slot_ok ? BS_SCAN : BS_DONE;
						default:
							state_d = BS_DONE;
					endcase
				end
			end
			BS_SCAN: begin
				if (hit) begin
					if ((kind_q inside {CMD_ERASE_KEY, CMD_ERASE_SLOT}) && below_last) begin
						state_d = BS_MOVE;
					end else begin
						state_d = BS_DONE;
					end
				end else if (!below_last) begin
					state_d = BS_DONE;
				end
			end
			BS_MOVE: state_d = BS_DONE;
			BS_DONE: begin
				if (out_free) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// datapath controls and next data values
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = AW'(count_q);
		ram_wdata    = {act_key, act_val};
		ram_raddr    = cur_q;
		cur_d        = cur_q;
		count_d      = count_q;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		res_slot_d   = res_slot_q;
		case (state_q)
			BS_IDLE: begin
				if (cmd_valid) begin
					res_status_d = ST_OK;
					res_value_d  = '0;
					res_slot_d   = '0;
					cur_d        = '0;
					ram_raddr    = '0;
					case (cmd_ctl.kind)
						CMD_ERASE_SLOT: begin
							if (slot_ok) begin
								cur_d     = AW'(cmd_ctl.slot);
								ram_raddr = AW'(cmd_ctl.slot);
							end else begin
								res_status_d = ST_FULL;
							end
						end
						CMD_CLEAR: count_d = '0;
						default: ;
					endcase
				end
			end
			BS_SCAN: begin
				if (hit) begin
					res_value_d = rd_val;
					res_slot_d  = cur_q;
					case (kind_q)
						CMD_INSERT: res_status_d = ST_PRESENT;
						CMD_ERASE_KEY, CMD_ERASE_SLOT: begin
							// fetch the last entry to fill the hole, or just shrink
							if (below_last) begin
								ram_raddr = AW'(count_q - CNT_W'(1));
							end else begin
								count_d = count_q - CNT_W'(1);
							end
						end
						default: ;
					endcase
				end else if (below_last) begin
					cur_d     = cur_q + AW'(1);
					ram_raddr = cur_q + AW'(1);
				end
			end
			BS_MOVE: begin
				// last entry read back now lands in the freed slot
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				ram_wdata = ram_rdata;
				count_d   = count_q - CNT_W'(1);
			end
			default: ;
		endcase
		// no match: append on insert (full status when the table is full), else report missing
		if (miss_go) begin
			case (act_kind)
				CMD_INSERT: begin
					if (tbl_full) begin
						res_status_d = ST_FULL;
					end else begin
						ram_we       = 1'b1;
						ram_waddr    = AW'(count_q);
						ram_wdata    = {act_key, act_val};
						res_status_d = ST_OK;
						res_value_d  = act_val;
						res_slot_d   = AW'(count_q);
						count_d      = count_q + CNT_W'(1);
					end
				end
				default: res_status_d = ST_MISSING;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if ((state_q == BS_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command, scan and result payload registers
	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		res_status_q <= res_status_d;
		res_value_q  <= res_value_d;
		res_slot_q   <= res_slot_d;
		if (start) begin
			kind_q <= cmd_ctl.kind;
			key_q  <= cmd_key;
			val_q  <= cmd_value;
		end
		if ((state_q == BS_DONE) && out_free) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_slot_q   <= res_slot_q;
			out_count_q  <= count_q;
		end
	end

	// response port
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_value = PORT_VALUE_W'(out_value_q);
	assign rsp.found_slot  = PORT_SLOT_W'(out_slot_q);
	assign rsp.entry_count = PORT_COUNT_W'(out_count_q);

	`LKVT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count over capacity")
	`LKVT_ASSERT_NOW(a_scan_in_range, state_q == BS_SCAN, CNT_W'(cur_q) < count_q, "scan slot past count")
	`LKVT_ASSERT_NOW(a_write_phase, ram_we, (state_q == BS_MOVE) || miss_go, "stray entry write")
	`LKVT_ASSERT_NEXT(a_result_loaded, (state_q == BS_DONE) && out_free, out_valid_q && (state_q == BS_IDLE), "result not loaded")
	`LKVT_ASSERT_NEXT(a_move_shrinks, state_q == BS_MOVE, count_q == $past(count_q) - CNT_W'(1), "erase did not shrink")
endmodule

### rtl/linear_key_value_table.sv
// Fixed-capacity key/value table kept as a packed unsorted array of entries. Requests pass
// through a two-entry command queue to a sequencer that reads one entry per cycle from a
// single-read-port entry RAM. A find, insert or erase by key scans from slot 0 until it
// matches or has read all entry_count entries; an erase that has to move the last entry
// into the freed slot then writes it there in a separate move state. Clear, erase at a bad
// slot and unknown operation codes skip the scan. Each request yields exactly one response,
// held in an output register while new requests keep entering the queue until it is full.
module linear_key_value_table #(
	parameter int CAPACITY    = lkvt_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH   = lkvt_pkg::DEF_KEY_WIDTH,
	parameter int VALUE_WIDTH = lkvt_pkg::DEF_VALUE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	lkvt_req_if.sink   req,
	lkvt_rsp_if.source rsp
);
	import lkvt_pkg::*;

	logic                   cmd_valid;
	logic                   cmd_ready;
	cmd_ctl_t               cmd_ctl;
	logic [KEY_WIDTH-1:0]   cmd_key;
	logic [VALUE_WIDTH-1:0] cmd_value;

	// request decode and queue
	lkvt_front #(
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_ctl   (cmd_ctl),
		.cmd_key   (cmd_key),
		.cmd_value (cmd_value)
	);

	// table sequencer and response register
	lkvt_back #(
		.CAPACITY    (CAPACITY),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_ctl   (cmd_ctl),
		.cmd_key   (cmd_key),
		.cmd_value (cmd_value),
		.rsp       (rsp)
	);
endmodule

### tb/sv/linear_key_value_table_tb.sv
// Self-checking testbench for the linear key/value table: directed rows, then random episodes.
module linear_key_value_table_tb;
	import lkvt_pkg::*;

	localparam int CAP          = DEF_CAPACITY;
	localparam int ITEM_TARGET  = 1150;
	localparam int QUIET_ITEMS  = 150;
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_REPORTS  = 50;

	// Codes 5 to 7 are no-ops
	localparam logic [OP_W-1:0] OPC_NOP_LO  = 3'd5;
	localparam logic [OP_W-1:0] OPC_NOP_MID = 3'd6;
	localparam logic [OP_W-1:0] OPC_NOP_HI  = 3'd7;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic [PORT_KEY_W-1:0]   key;
		logic [PORT_VALUE_W-1:0] value;
		logic [PORT_SLOT_W-1:0]  slot;
	} lookup_req_t;

	typedef struct {
		status_t                 status;
		logic [PORT_VALUE_W-1:0] value;
		logic [PORT_SLOT_W-1:0]  slot;
		logic [PORT_COUNT_W-1:0] count;
	} lookup_rsp_t;

	typedef struct {
		lookup_req_t req;
		bit          typed;
		lookup_rsp_t rsp;
	} directed_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lkvt_req_if req_ch ();
	lkvt_rsp_if rsp_ch ();

	linear_key_value_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	// Shadow copy of the table contents
	logic [PORT_KEY_W-1:0]   shadow_keys   [CAP];
	logic [PORT_VALUE_W-1:0] shadow_values [CAP];
	int                      shadow_count;

	lookup_rsp_t             expected_responses [$];
	directed_row_t           directed_rows [$];
	logic [PORT_KEY_W-1:0]   key_pool [24];
	int                      fail_count;
	int                      cycle_count;
	int                      items_sent;
	int                      idle_pct;

	task automatic report_mismatch(input string what);
		if (fail_count < MAX_REPORTS)
			$display("MISMATCH cycle %0d: %s", cycle_count, what);
		fail_count++;
	endtask

	// Remove a slot: the last entry moves into the hole
	function automatic void drop_slot(input int s);
		if (s < shadow_count - 1) begin
			shadow_keys[s]   = shadow_keys[shadow_count - 1];
			shadow_values[s] = shadow_values[shadow_count - 1];
		end
		shadow_count--;
	endfunction

	// Apply one request to the shadow table and return the response it should give
	function automatic lookup_rsp_t table_apply(input lookup_req_t r);
		lookup_rsp_t res;
		int          hit;
		res.status = ST_OK;
		res.value  = '0;
		res.slot   = '0;
		hit = -1;
		for (int i = 0; i < shadow_count; i++)
			if (hit < 0 && shadow_keys[i] == r.key)
				hit = i;
		case (r.op)
			OPC_FIND: begin
				if (hit >= 0) begin
					res.value = shadow_values[hit];
					res.slot  = PORT_SLOT_W'(hit);
				end else
					res.status = ST_MISSING;
			end
			OPC_INSERT: begin
				if (hit >= 0) begin
					res.status = ST_PRESENT;
					res.value  = shadow_values[hit];
					res.slot   = PORT_SLOT_W'(hit);
				end else if (shadow_count >= CAP)
					res.status = ST_FULL;
				else begin
					shadow_keys[shadow_count]   = r.key;
					shadow_values[shadow_count] = r.value;
					res.value = r.value;
					res.slot  = PORT_SLOT_W'(shadow_count);
					shadow_count++;
				end
			end
			OPC_ERASE_KEY: begin
				if (hit >= 0) begin
					res.value = shadow_values[hit];
					res.slot  = PORT_SLOT_W'(hit);
					drop_slot(hit);
				end else
					res.status = ST_MISSING;
			end
			OPC_ERASE_SLOT: begin
				if (r.slot < shadow_count) begin
					res.value = shadow_values[r.slot];
					res.slot  = r.slot;
					drop_slot(r.slot);
				end else
					res.status = ST_FULL;
			end
			OPC_CLEAR: shadow_count = 0;
			default: ;
		endcase
		res.count = PORT_COUNT_W'(shadow_count);
		return res;
	endfunction

	task automatic add_row(input logic [OP_W-1:0] op, input logic [31:0] key, input logic [31:0] value,
			input logic [3:0] slot, input bit typed, input status_t st, input logic [31:0] fv,
			input logic [3:0] fs, input logic [4:0] cnt);
		directed_row_t row;
		row.req   = '{op, key, value, slot};
		row.typed = typed;
		row.rsp   = '{st, fv, fs, cnt};
		directed_rows.push_back(row);
	endtask

	// Present one request and hold it until the transfer; optional idle burst afterwards
	task automatic send_item(input lookup_req_t r, input bit typed, input lookup_rsp_t typed_rsp);
		lookup_rsp_t predicted;
		req_ch.valid     <= 1'b1;
		req_ch.operation <= r.op;
		req_ch.req_key   <= r.key;
		req_ch.req_value <= r.value;
		req_ch.req_slot  <= r.slot;
		do @(posedge clk); while (!req_ch.ready);
		predicted = table_apply(r);
		expected_responses.push_back(typed ? typed_rsp : predicted);
		items_sent++;
		if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
			idle_pct = 0;
		if ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_random(input lookup_req_t r);
		lookup_rsp_t unused;
		unused = '{ST_OK, '0, '0, '0};
		send_item(r, 1'b0, unused);
	endtask

	// Hold the sender off until every outstanding response has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
	endtask

	// Mostly keys that are stored or in the pool, so finds and erases hit
	function automatic logic [31:0] pick_key();
		int w;
		w = $urandom_range(0, 99);
		if (shadow_count > 0 && w < 55)
			return shadow_keys[$urandom_range(0, shadow_count - 1)];
		else if (w < 85)
			return key_pool[$urandom_range(0, 23)];
		return $urandom;
	endfunction

	function automatic lookup_req_t mixed_req();
		lookup_req_t r;
		int          w;
		r.op    = OPC_FIND;
		r.key   = pick_key();
		r.value = $urandom;
		r.slot  = PORT_SLOT_W'($urandom_range(0, 15));
		w = $urandom_range(0, 99);
		if (w < 30)
			r.op = OPC_FIND;
		else if (w < 60)
			r.op = OPC_INSERT;
		else if (w < 75)
			r.op = OPC_ERASE_KEY;
		else if (w < 92) begin
			r.op = OPC_ERASE_SLOT;
			if ($urandom_range(0, 9) != 0)
				r.slot = PORT_SLOT_W'($urandom_range(0, shadow_count));
		end else if (w < 95)
			r.op = OPC_CLEAR;
		else
			r.op = OP_W'($urandom_range(OPC_NOP_LO, OPC_NOP_HI));
		return r;
	endfunction

	// Timeout guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d responses outstanding",
				cycle_count, expected_responses.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Response checker
	always @(posedge clk) begin : rsp_check
		lookup_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_responses.size() == 0)
				report_mismatch("response with nothing outstanding");
			else begin
				want = expected_responses.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
				if (rsp_ch.found_value !== want.value)
					report_mismatch($sformatf("found_value %h, expected %h",
						rsp_ch.found_value, want.value));
				if (rsp_ch.found_slot !== want.slot)
					report_mismatch($sformatf("found_slot %0d, expected %0d",
						rsp_ch.found_slot, want.slot));
				if (rsp_ch.entry_count !== want.count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						rsp_ch.entry_count, want.count));
			end
		end
	end

	// Response back-pressure in short random bursts
	initial begin : rsp_pacer
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= 1'b1;
		end
	end

	// Stimulus
	initial begin : stim
		lookup_req_t r;
		int          kind;
		bit          first;
		req_ch.valid     = 1'b0;
		req_ch.operation = OPC_FIND;
		req_ch.req_key   = '0;
		req_ch.req_value = '0;
		req_ch.req_slot  = '0;
		shadow_count = 0;
		fail_count   = 0;
		cycle_count  = 0;
		items_sent   = 0;
		idle_pct     = 25;
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;

		// Directed rows: empty table, key and value extremes, duplicate insert,
		// no-op codes, bad slots, erase of the last slot, erase that moves an entry
		add_row(OPC_FIND,       32'h0000_0000, 32'h0,         4'd0,  1, ST_MISSING, 32'h0, 4'd0, 5'd0);
		add_row(OPC_ERASE_SLOT, 32'h0000_0000, 32'h0,         4'd0,  1, ST_FULL,    32'h0, 4'd0, 5'd0);
		add_row(OPC_ERASE_KEY,  32'hFFFF_FFFF, 32'h0,         4'd0,  1, ST_MISSING, 32'h0, 4'd0, 5'd0);
		add_row(OPC_INSERT,     32'h0000_0000, 32'hFFFF_FFFF, 4'd0,  1, ST_OK, 32'hFFFF_FFFF, 4'd0, 5'd1);
		add_row(OPC_INSERT,     32'hFFFF_FFFF, 32'h0000_0000, 4'd15, 1, ST_OK, 32'h0, 4'd1, 5'd2);
		add_row(OPC_INSERT,     32'h0000_0000, 32'h0000_0001, 4'd0,
			1, ST_PRESENT, 32'hFFFF_FFFF, 4'd0, 5'd2);
		add_row(OPC_FIND,       32'hFFFF_FFFF, 32'h0,         4'd0,  1, ST_OK, 32'h0, 4'd1, 5'd2);
		add_row(OPC_INSERT,     32'h1234_5678, 32'h5555_AAAA, 4'd0,  1, ST_OK, 32'h5555_AAAA, 4'd2, 5'd3);
		add_row(OPC_INSERT,     32'h8000_0001, 32'hAAAA_5555, 4'd0,  1, ST_OK, 32'hAAAA_5555, 4'd3, 5'd4);
		add_row(OPC_NOP_LO,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1, ST_OK, 32'h0, 4'd0, 5'd4);
		add_row(OPC_NOP_HI,     32'h0000_0000, 32'h0,         4'd0,  1, ST_OK, 32'h0, 4'd0, 5'd4);
		add_row(OPC_ERASE_SLOT, 32'h0000_0000, 32'h0,         4'd15, 1, ST_FULL, 32'h0, 4'd0, 5'd4);
		add_row(OPC_ERASE_SLOT, 32'h0000_0000, 32'h0,         4'd3,  1, ST_OK, 32'hAAAA_5555, 4'd3, 5'd3);
		add_row(OPC_ERASE_KEY,  32'h0000_0000, 32'h0,         4'd0,  1, ST_OK, 32'hFFFF_FFFF, 4'd0, 5'd2);
		add_row(OPC_FIND,       32'h1234_5678, 32'h0,         4'd0,  0, ST_OK, 32'h0, 4'd0, 5'd0);
		add_row(OPC_FIND,       32'h0000_0000, 32'h0,         4'd0,  1, ST_MISSING, 32'h0, 4'd0, 5'd2);
		add_row(OPC_ERASE_SLOT, 32'h0000_0000, 32'h0,         4'd2,  1, ST_FULL, 32'h0, 4'd0, 5'd2);
		add_row(OPC_NOP_MID,    32'h1234_5678, 32'h1,         4'd1,  0, ST_OK, 32'h0, 4'd0, 5'd0);
		add_row(OPC_CLEAR,      32'h0000_0000, 32'h0,         4'd0,  1, ST_OK, 32'h0, 4'd0, 5'd0);
		add_row(OPC_FIND,       32'h1234_5678, 32'h0,         4'd0,  1, ST_MISSING, 32'h0, 4'd0, 5'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
		wait_drained();

		// Random episodes: fill to full, drain to empty, or a mixed run
		first = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			kind = first ? 0 : $urandom_range(0, 3);
			first = 1'b0;
			if (items_sent < ITEM_TARGET - QUIET_ITEMS)
				idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
			case (kind)
				0: begin
					while (shadow_count < CAP) begin
						r.op    = OPC_INSERT;
						r.key   = ($urandom_range(0, 9) < 7) ? $urandom : pick_key();
						r.value = $urandom;
						r.slot  = PORT_SLOT_W'($urandom_range(0, 15));
						send_random(r);
					end
					// a few more against the full table
					repeat ($urandom_range(1, 3)) begin
						r.op    = OPC_INSERT;
						r.key   = pick_key();
						r.value = $urandom;
						r.slot  = PORT_SLOT_W'($urandom_range(0, 15));
						send_random(r);
					end
				end
				1: begin
					while (shadow_count > 0) begin
						r.value = $urandom;
						if ($urandom_range(0, 1) == 0) begin
							r.op   = OPC_ERASE_KEY;
							r.key  = shadow_keys[$urandom_range(0, shadow_count - 1)];
							r.slot = PORT_SLOT_W'($urandom_range(0, 15));
						end else begin
							r.op   = OPC_ERASE_SLOT;
							r.key  = $urandom;
							r.slot = PORT_SLOT_W'($urandom_range(0, shadow_count - 1));
						end
						send_random(r);
					end
					r.op    = $urandom_range(0, 1) ? OPC_ERASE_KEY : OPC_ERASE_SLOT;
					r.key   = $urandom;
					r.value = $urandom;
					r.slot  = PORT_SLOT_W'($urandom_range(0, 15));
					send_random(r);
				end
				default: begin
					repeat ($urandom_range(20, 60))
						send_random(mixed_req());
				end
			endcase
			if ($urandom_range(0, 2) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
